// File: src/drrh_pkg.sv
// drrh_pkg: shared types and codes of the routine-control request handler
// no dependencies; used by the interfaces and all modules
`timescale 1ns / 1ps

package drrh_pkg;

  // input modes
  localparam logic [1:0] MODE_REQUEST = 2'd0;
  localparam logic [1:0] MODE_LOAD    = 2'd1;
  localparam logic [1:0] MODE_POST    = 2'd2;
  localparam logic [1:0] MODE_RSVD    = 2'd3;

  // sub-functions
  localparam logic [7:0] SUB_START   = 8'h01;
  localparam logic [7:0] SUB_STOP    = 8'h02;
  localparam logic [7:0] SUB_RESULTS = 8'h03;

  localparam logic [7:0] POS_RESP_SID = 8'h71;
  localparam logic [8:0] HDR_BYTES    = 9'd4;

  // run states
  localparam logic [1:0] RUN_IDLE    = 2'd0;
  localparam logic [1:0] RUN_RUNNING = 2'd1;
  localparam logic [1:0] RUN_STOPPED = 2'd2;
  localparam logic [1:0] RUN_RESULTS = 2'd3;

  // response status
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_NEG    = 2'd1;
  localparam logic [1:0] STAT_BUFERR = 2'd2;

  // negative response codes
  localparam logic [2:0] NRC_NONE       = 3'd0;
  localparam logic [2:0] NRC_SUBFN      = 3'd1;
  localparam logic [2:0] NRC_RANGE      = 3'd2;
  localparam logic [2:0] NRC_SECURITY   = 3'd3;
  localparam logic [2:0] NRC_CONDITIONS = 3'd4;

  // register index of entry_count
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  sub_function;
    logic [15:0] rtn_id;
    logic [7:0]  sess_lvl;
    logic        sec_ok;
    logic [7:0]  resp_capacity;
    logic [3:0]  slot;
    logic [7:0]  min_lvl;
    logic        needs_security;
    logic [3:0]  byte_index;
    logic [7:0]  data_byte;
    logic [4:0]  result_length;
  } req_t;

  typedef struct packed {
    logic [7:0] resp_byte;
    logic [1:0] status;
    logic [2:0] nrc;
    logic       last;
  } resp_t;

  // configuration seen by the core
  typedef struct packed {
    logic [4:0] entry_count;
  } cfg_t;

endpackage

// File: src/drrh_if.sv
// drrh_req_if / drrh_resp_if: valid/ready channels of the handler
// depends on drrh_pkg
`timescale 1ns / 1ps

interface drrh_req_if;
  logic           valid;
  logic           ready;
  drrh_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drrh_resp_if;
  logic            valid;
  logic            ready;
  drrh_pkg::resp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: src/drrh_apb_regs.sv
// drrh_apb_regs: apb register file holding entry_count
// depends on drrh_pkg
`timescale 1ns / 1ps

module drrh_apb_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output drrh_pkg::cfg_t    cfg_o
);

  logic [4:0] count_q;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == drrh_pkg::REG_ENTRY_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 5'd0;
    end else if (wr_en) begin
      count_q <= pwdata[4:0];
    end
  end

  assign prdata = (paddr[2] == drrh_pkg::REG_ENTRY_COUNT) ? {27'd0, count_q} : 32'd0;
  assign cfg_o.entry_count = count_q;

endmodule

// File: src/diag_routine_request_handler.sv
// diag_routine_request_handler: routine-control request handler top level
// depends on drrh_pkg, drrh_if (drrh_req_if, drrh_resp_if) and drrh_apb_regs
`timescale 1ns / 1ps
// usage
//   in_i takes one word per item: mode 1 loads a routine slot, mode 2 posts
//   one result byte, mode 0 serves a routine-control request. load and post
//   give no response word
//   out_o gives response words: a positive response is 0x71, sub-function,
//   id high, id low, then the routine's result bytes, last set on the final
//   one; a failed check or a too-small buffer gives a single word
//   the apb port sets entry_count, the number of slots searched from slot 0
// timing
//   the lookup reads one slot at a time from the entry memory, each in two
//   steps (read, then compare), up to the matching slot; then 4 header words,
//   one per cycle while out_o accepts, and each result byte in two steps
//   (result memory read, then load into the output register)
//   one item is handled at a time; in_i.ready is high only between items
// reset
//   run states and result lengths read as idle/zero through per-slot valid
//   bits cleared at reset; no clearing pass is needed; entry_count is zero
// stalls
//   an output register holds each word; while out_o.ready is low the
//   sequencer waits with no word lost or repeated

module diag_routine_request_handler #(
  parameter int TABLE_SLOTS      = 16,
  parameter int MAX_RESULT_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  drrh_req_if.sink          in_i,
  drrh_resp_if.source       out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int SW       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int RS_DEPTH = (TABLE_SLOTS * MAX_RESULT_BYTES > 0) ?
                            TABLE_SLOTS * MAX_RESULT_BYTES : 1;
  localparam int RAW      = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1;
  localparam logic [6:0] SLOTS_W = 7'(TABLE_SLOTS);
  localparam logic [6:0] MAXB_W  = 7'(MAX_RESULT_BYTES);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_CMP  = 6'b000100,
    S_ERR  = 6'b001000,
    S_HDR  = 6'b010000,
    S_RD   = 6'b100000
  } state_e;

  // byte-send states share S_RD: a sub-phase flag tells read from send
  state_e state_q, state_d;

  drrh_pkg::cfg_t cfg;

  drrh_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // entry memory: id, minimum session, security flag
  logic [24:0] ent_mem [TABLE_SLOTS];
  logic [24:0] ent_rd_q;
  // state memory: run state, result length
  logic [6:0]  st_mem [TABLE_SLOTS];
  logic [6:0]  st_rd_q;
  logic [TABLE_SLOTS-1:0] st_vld_q;
  logic        vld_rd_q;
  // result byte memory
  logic [7:0]  rs_mem [RS_DEPTH];
  logic [7:0]  rs_rd_q;

  drrh_pkg::req_t req_q;
  logic [6:0]  idx_q, idx_d;
  logic [6:0]  active_q, active_d;
  logic [4:0]  len_q, len_d;
  logic [4:0]  bi_q, bi_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        phase_q, phase_d;
  logic [RAW-1:0] base_q, base_d;
  logic [1:0]  err_stat_q, err_stat_d;
  logic [2:0]  err_nrc_q, err_nrc_d;

  logic        out_vld_q;
  drrh_pkg::resp_t out_q, out_d;
  logic        out_ld, out_free;

  logic        in_acc;
  logic        slot_ok;

  // memory write/read controls
  logic        ent_we, st_we, rs_we;
  logic [SW-1:0] ent_wa, st_wa, rd_a;
  logic [24:0] ent_wd;
  logic [6:0]  st_wd;
  logic [RAW-1:0] rs_wa, rs_ra;
  logic [4:0]  post_len;
  logic [12:0] post_addr;

  // compare-stage decode
  logic [15:0] c_id;
  logic [7:0]  c_min;
  logic        c_sec;
  logic [1:0]  c_run;
  logic [4:0]  c_len;
  logic [4:0]  c_eff_len;
  logic [12:0] c_base;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign slot_ok    = {3'd0, in_i.data.slot} < SLOTS_W;

  assign post_len  = ({2'd0, in_i.data.result_length} > MAXB_W) ?
                     5'(MAX_RESULT_BYTES) : in_i.data.result_length;
  assign post_addr = 13'(in_i.data.slot) * 13'(MAX_RESULT_BYTES) + 13'(in_i.data.byte_index);

  assign c_id  = ent_rd_q[24:9];
  assign c_min = ent_rd_q[8:1];
  assign c_sec = ent_rd_q[0];
  assign c_run = vld_rd_q ? st_rd_q[6:5] : drrh_pkg::RUN_IDLE;
  assign c_len = vld_rd_q ? st_rd_q[4:0] : 5'd0;
  assign c_eff_len = (req_q.sub_function == drrh_pkg::SUB_RESULTS) ? c_len : 5'd0;
  assign c_base = 13'(idx_q) * 13'(MAX_RESULT_BYTES);

  assign rd_a  = SW'(idx_q);
  assign rs_ra = base_q + RAW'(bi_q);

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    active_d   = active_q;
    len_d      = len_q;
    bi_d       = bi_q;
    cnt_d      = cnt_q;
    phase_d    = phase_q;
    base_d     = base_q;
    err_stat_d = err_stat_q;
    err_nrc_d  = err_nrc_q;
    out_ld     = 1'b0;
    out_d      = out_q;
    ent_we     = 1'b0;
    ent_wa     = SW'(in_i.data.slot);
    ent_wd     = {in_i.data.rtn_id, in_i.data.min_lvl, in_i.data.needs_security};
    st_we      = 1'b0;
    st_wa      = SW'(in_i.data.slot);
    st_wd      = {drrh_pkg::RUN_IDLE, 5'd0};
    rs_we      = 1'b0;
    rs_wa      = RAW'(post_addr);

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_i.data.mode)
            drrh_pkg::MODE_LOAD: begin
              if (slot_ok) begin
                ent_we = 1'b1;
                st_we  = 1'b1;
              end
            end
            drrh_pkg::MODE_POST: begin
              if (slot_ok) begin
                st_we = 1'b1;
                st_wd = {drrh_pkg::RUN_RESULTS, post_len};
                rs_we = {3'd0, in_i.data.byte_index} < MAXB_W;
              end
            end
            drrh_pkg::MODE_REQUEST: begin
              active_d = ({2'd0, cfg.entry_count} > SLOTS_W) ?
                         SLOTS_W : {2'd0, cfg.entry_count};
              idx_d    = 7'd0;
              if (in_i.data.sub_function < drrh_pkg::SUB_START ||
                  in_i.data.sub_function > drrh_pkg::SUB_RESULTS) begin
                err_stat_d = drrh_pkg::STAT_NEG;
                err_nrc_d  = drrh_pkg::NRC_SUBFN;
                state_d    = S_ERR;
              end else if (active_d == 7'd0) begin
                err_stat_d = drrh_pkg::STAT_NEG;
                err_nrc_d  = drrh_pkg::NRC_RANGE;
                state_d    = S_ERR;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        // memories are read at idx_q this cycle
        state_d = S_CMP;
      end
      S_CMP: begin
        if (c_id != req_q.rtn_id) begin
          if (idx_q + 7'd1 >= active_q) begin
            err_stat_d = drrh_pkg::STAT_NEG;
            err_nrc_d  = drrh_pkg::NRC_RANGE;
            state_d    = S_ERR;
          end else begin
            idx_d   = idx_q + 7'd1;
            state_d = S_READ;
          end
        end else if (req_q.sess_lvl < c_min) begin
          err_stat_d = drrh_pkg::STAT_NEG;
          err_nrc_d  = drrh_pkg::NRC_RANGE;
          state_d    = S_ERR;
        end else if (c_sec && !req_q.sec_ok) begin
          err_stat_d = drrh_pkg::STAT_NEG;
          err_nrc_d  = drrh_pkg::NRC_SECURITY;
          state_d    = S_ERR;
        end else if ((req_q.sub_function == drrh_pkg::SUB_STOP &&
                      c_run != drrh_pkg::RUN_RUNNING) ||
                     (req_q.sub_function == drrh_pkg::SUB_RESULTS &&
                      c_run != drrh_pkg::RUN_RESULTS)) begin
          err_stat_d = drrh_pkg::STAT_NEG;
          err_nrc_d  = drrh_pkg::NRC_CONDITIONS;
          state_d    = S_ERR;
        end else if ({1'b0, req_q.resp_capacity} < drrh_pkg::HDR_BYTES + 9'(c_eff_len)) begin
          err_stat_d = drrh_pkg::STAT_BUFERR;
          err_nrc_d  = drrh_pkg::NRC_NONE;
          state_d    = S_ERR;
        end else begin
          st_wa = rd_a;
          if (req_q.sub_function == drrh_pkg::SUB_START) begin
            st_we = 1'b1;
            st_wd = {drrh_pkg::RUN_RUNNING, c_len};
          end else if (req_q.sub_function == drrh_pkg::SUB_STOP) begin
            st_we = 1'b1;
            st_wd = {drrh_pkg::RUN_STOPPED, c_len};
          end
          len_d   = c_eff_len;
          base_d  = RAW'(c_base);
          cnt_d   = 2'd0;
          state_d = S_HDR;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_ld  = 1'b1;
          out_d   = '{resp_byte: 8'd0, status: err_stat_q, nrc: err_nrc_q, last: 1'b1};
          state_d = S_IDLE;
        end
      end
      S_HDR: begin
        if (out_free) begin
          out_ld = 1'b1;
          out_d.status = drrh_pkg::STAT_OK;
          out_d.nrc    = drrh_pkg::NRC_NONE;
          out_d.last   = 1'b0;
          case (cnt_q)
            2'd0: out_d.resp_byte = drrh_pkg::POS_RESP_SID;
            2'd1: out_d.resp_byte = req_q.sub_function;
            2'd2: out_d.resp_byte = req_q.rtn_id[15:8];
            default: begin
              out_d.resp_byte = req_q.rtn_id[7:0];
              out_d.last      = (len_q == 5'd0);
            end
          endcase
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            bi_d    = 5'd0;
            phase_d = 1'b0;
            state_d = (len_q == 5'd0) ? S_IDLE : S_RD;
          end
        end
      end
      S_RD: begin
        // phase 0: result memory read, phase 1: send the byte
        if (!phase_q) begin
          phase_d = 1'b1;
        end else if (out_free) begin
          out_ld  = 1'b1;
          out_d   = '{resp_byte: rs_rd_q, status: drrh_pkg::STAT_OK,
                      nrc: drrh_pkg::NRC_NONE, last: (bi_q + 5'd1 == len_q)};
          phase_d = 1'b0;
          bi_d    = bi_q + 5'd1;
          if (bi_q + 5'd1 == len_q) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      st_vld_q  <= '0;
    end else begin
      state_q <= state_d;
      if (out_ld) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (st_we) begin
        st_vld_q[st_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_i.data;
    end
    if (out_ld) begin
      out_q <= out_d;
    end
    idx_q      <= idx_d;
    active_q   <= active_d;
    len_q      <= len_d;
    bi_q       <= bi_d;
    cnt_q      <= cnt_d;
    phase_q    <= phase_d;
    base_q     <= base_d;
    err_stat_q <= err_stat_d;
    err_nrc_q  <= err_nrc_d;
  end

  // synchronous memories, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_rd_q <= ent_mem[rd_a];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    st_rd_q  <= st_mem[rd_a];
    vld_rd_q <= st_vld_q[rd_a];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_wa] <= in_i.data.data_byte;
    end
    rs_rd_q <= rs_mem[rs_ra];
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

endmodule
